FILE: src/ffbt_pkg.sv
// Shared types and constants of the first-fit boundary-tag allocator.
`default_nettype none

package ffbt_pkg;

  // Field widths of the request and response beats
  localparam int REQ_W  = 13;
  localparam int OFF_W  = 13;
  // Byte offset to word index: words are 8 bytes
  localparam int WORD_SHIFT = 3;
  // Word index carried by a byte offset
  localparam int BIDX_W = OFF_W - WORD_SHIFT;
  // Words needed by a request: ceil(bytes/8) + 2 tag words
  localparam int NEED_W = REQ_W - WORD_SHIFT + 1;
  localparam int TAG_WORDS = 2;
  // Leftover below this many words is not split off
  localparam int MIN_SPLIT_WORDS = 3;

  localparam int HEAP_WORDS_DEF = 1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_NO_FIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_F_RD,
    S_F_WALK,
    S_F_TEST,
    S_F_BLK,
    S_F_NXT,
    S_F_PRV,
    S_F_PCHK,
    S_W_HDR,
    S_W_TRL,
    S_RESP
  } ffbt_state_e;

endpackage

`default_nettype wire

FILE: src/ffbt_req_if.sv
// Request channel: command, byte count and offset to release.
`default_nettype none

interface ffbt_req_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [ffbt_pkg::REQ_W-1:0] req_bytes;
  logic [ffbt_pkg::OFF_W-1:0] free_offset;

  modport source (output valid, output cmd, output req_bytes, output free_offset,
                  input ready);
  modport sink   (input valid, input cmd, input req_bytes, input free_offset,
                  output ready);
endinterface

`default_nettype wire

FILE: src/ffbt_rsp_if.sv
// Response channel: status and granted payload offset.
`default_nettype none

interface ffbt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [ffbt_pkg::OFF_W-1:0] payload_offset;

  modport source (output valid, output status, output payload_offset, input ready);
  modport sink   (input valid, input status, input payload_offset, output ready);
endinterface

`default_nettype wire

FILE: src/first_fit_boundary_tag_allocator_unit.sv
// First-fit boundary-tag heap allocator: tag memory, sequencer and response register.
//
// The heap is HEAP_WORDS words of 8 bytes, each block framed by a header and a
// trailer tag that hold its size in words and a used bit; all tags live in one
// single-port tag memory with a registered read, and every step of the block
// goes through that port, one access per cycle. One request beat is taken at a
// time and req_i.ready stays low until its response has been placed in the
// output register. An allocate reads the tag of every block ahead of the fit
// and of the chosen one, inspects it, makes 2 tag writes (4 when the leftover
// is split) and posts the response. A free walks the blocks ahead of the one
// named, reads that block and both neighbours, and writes the merged block's
// two tags; a misaligned offset is answered without a walk. A failed allocate
// walks the whole heap. The response register lets a new request enter while
// the previous response is still waiting to be taken. Out of reset the heap is
// one free block; only its two tags are reset, through two flags, so no
// clearing pass is needed.
`default_nettype none

module first_fit_boundary_tag_allocator_unit #(
  parameter int HEAP_WORDS = ffbt_pkg::HEAP_WORDS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ffbt_req_if.sink   req_i,
  ffbt_rsp_if.source rsp_o
);

  // Pointer/size width holds HEAP_WORDS itself; address width indexes it
  localparam int PW = $clog2(HEAP_WORDS + 1);
  localparam int AW = $clog2(HEAP_WORDS);
  localparam int TW = PW + 1;
  // Compare width covering pointers, sizes, word needs and offset indexes
  localparam int MW = ((PW > ffbt_pkg::NEED_W) ? PW : ffbt_pkg::NEED_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(HEAP_WORDS - 1);
  localparam logic [TW-1:0] RESET_TAG = {PW'(HEAP_WORDS), 1'b0};

  ffbt_pkg::ffbt_state_e state_q, state_d;

  logic [PW-1:0]                  p_q, p_d;
  logic [ffbt_pkg::NEED_W-1:0]    need_q, need_d;
  logic [ffbt_pkg::BIDX_W-1:0]    b_q, b_d;
  logic [PW-1:0]                  blk_start_q, blk_start_d;
  logic [PW-1:0]                  blk_size_q, blk_size_d;
  logic                           blk_used_q, blk_used_d;
  logic [PW-1:0]                  rest_size_q, rest_size_d;
  logic                           split_q, split_d;
  logic                           res_status_q, res_status_d;
  logic [ffbt_pkg::OFF_W-1:0]     res_off_q, res_off_d;
  logic                           rsp_valid_q, rsp_valid_d;
  logic                           rsp_status_q, rsp_status_d;
  logic [ffbt_pkg::OFF_W-1:0]     rsp_off_q, rsp_off_d;

  // Tag memory and reset flags for the two tags of the initial block
  logic [TW-1:0] tag_mem [HEAP_WORDS];
  logic [TW-1:0] rd_data_q;
  logic          rd_ovr_q;
  logic          hdr0_set_q, last_set_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [TW-1:0] wr_tag;

  logic [TW-1:0] tag;
  logic [PW-1:0] tag_size;
  logic          tag_used;
  logic [PW-1:0] p_next;
  logic [PW:0]   grant_word;
  logic [PW+ffbt_pkg::WORD_SHIFT:0] grant_bytes;
  logic [PW-1:0] n_ptr;
  logic [ffbt_pkg::BIDX_W-1:0] off_idx;

  assign tag      = rd_ovr_q ? RESET_TAG : rd_data_q;
  assign tag_size = tag[TW-1:1];
  assign tag_used = tag[0];
  assign p_next   = PW'(p_q + tag_size);
  // Payload sits one word past the header; offsets wrap to the field width
  assign grant_word  = (PW + 1)'(p_q) + (PW + 1)'(1);
  assign grant_bytes = {grant_word, {ffbt_pkg::WORD_SHIFT{1'b0}}};
  assign n_ptr       = PW'(PW'(b_q) + tag_size);
  assign off_idx     = req_i.free_offset[ffbt_pkg::OFF_W-1:ffbt_pkg::WORD_SHIFT];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (rd_en) begin
      rd_data_q <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_set_q <= 1'b0;
      last_set_q <= 1'b0;
      rd_ovr_q   <= 1'b0;
    end else begin
      if (wr_en && wr_addr == '0) begin
        hdr0_set_q <= 1'b1;
      end
      if (wr_en && wr_addr == LAST_ADDR) begin
        last_set_q <= 1'b1;
      end
      if (rd_en) begin
        rd_ovr_q <= (rd_addr == '0 && !hdr0_set_q) ||
                    (rd_addr == LAST_ADDR && !last_set_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffbt_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q          <= p_d;
    need_q       <= need_d;
    b_q          <= b_d;
    blk_start_q  <= blk_start_d;
    blk_size_q   <= blk_size_d;
    blk_used_q   <= blk_used_d;
    rest_size_q  <= rest_size_d;
    split_q      <= split_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    rsp_status_q <= rsp_status_d;
    rsp_off_q    <= rsp_off_d;
  end

  assign req_i.ready          = (state_q == ffbt_pkg::S_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.payload_offset = rsp_off_q;

  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    need_d       = need_q;
    b_d          = b_q;
    blk_start_d  = blk_start_q;
    blk_size_d   = blk_size_q;
    blk_used_d   = blk_used_q;
    rest_size_d  = rest_size_q;
    split_d      = split_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    rsp_status_d = rsp_status_q;
    rsp_off_d    = rsp_off_q;
    // Drop the response once it is taken
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rd_en        = 1'b0;
    rd_addr      = AW'(p_q);
    wr_en        = 1'b0;
    wr_addr      = AW'(blk_start_q);
    wr_tag       = {blk_size_q, blk_used_q};

    unique case (state_q)
      ffbt_pkg::S_IDLE: begin
        if (req_i.valid) begin
          p_d          = '0;
          res_status_d = ffbt_pkg::STATUS_DONE;
          res_off_d    = '0;
          need_d = ffbt_pkg::NEED_W'(req_i.req_bytes[ffbt_pkg::REQ_W-1:ffbt_pkg::WORD_SHIFT])
                 + ffbt_pkg::NEED_W'(|req_i.req_bytes[ffbt_pkg::WORD_SHIFT-1:0])
                 + ffbt_pkg::NEED_W'(ffbt_pkg::TAG_WORDS);
          b_d    = off_idx - ffbt_pkg::BIDX_W'(1);
          if (req_i.cmd == ffbt_pkg::CMD_ALLOC) begin
            state_d = ffbt_pkg::S_A_RD;
          end else if (off_idx == '0 ||
                       req_i.free_offset[ffbt_pkg::WORD_SHIFT-1:0] != '0) begin
            // Misaligned or header-less offset: ignore the free
            state_d = ffbt_pkg::S_RESP;
          end else begin
            state_d = ffbt_pkg::S_F_RD;
          end
        end
      end

      ffbt_pkg::S_A_RD: begin
        if (MW'(p_q) >= MW'(HEAP_WORDS)) begin
          res_status_d = ffbt_pkg::STATUS_NO_FIT;
          state_d      = ffbt_pkg::S_RESP;
        end else begin
          rd_en   = 1'b1;
          state_d = ffbt_pkg::S_A_CHK;
        end
      end

      ffbt_pkg::S_A_CHK: begin
        if (tag_size == '0) begin
          res_status_d = ffbt_pkg::STATUS_NO_FIT;
          state_d      = ffbt_pkg::S_RESP;
        end else if (!tag_used && MW'(tag_size) >= MW'(need_q)) begin
          blk_start_d = p_q;
          blk_used_d  = 1'b1;
          res_off_d   = ffbt_pkg::OFF_W'(grant_bytes);
          rest_size_d = PW'(MW'(tag_size) - MW'(need_q));
          if (MW'(tag_size) - MW'(need_q) >= MW'(ffbt_pkg::MIN_SPLIT_WORDS)) begin
            blk_size_d = PW'(need_q);
            split_d    = 1'b1;
          end else begin
            blk_size_d = tag_size;
            split_d    = 1'b0;
          end
          state_d = ffbt_pkg::S_W_HDR;
        end else begin
          p_d     = p_next;
          state_d = ffbt_pkg::S_A_RD;
        end
      end

      ffbt_pkg::S_F_RD: begin
        if (MW'(p_q) < MW'(HEAP_WORDS) && MW'(p_q) < MW'(b_q)) begin
          rd_en   = 1'b1;
          state_d = ffbt_pkg::S_F_WALK;
        end else begin
          state_d = ffbt_pkg::S_F_TEST;
        end
      end

      ffbt_pkg::S_F_WALK: begin
        if (tag_size == '0) begin
          state_d = ffbt_pkg::S_RESP;
        end else begin
          p_d     = p_next;
          state_d = ffbt_pkg::S_F_RD;
        end
      end

      ffbt_pkg::S_F_TEST: begin
        if (MW'(p_q) != MW'(b_q) || MW'(b_q) >= MW'(HEAP_WORDS)) begin
          state_d = ffbt_pkg::S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(b_q);
          state_d = ffbt_pkg::S_F_BLK;
        end
      end

      ffbt_pkg::S_F_BLK: begin
        if (!tag_used) begin
          // Not an allocated block: double free or stray offset
          state_d = ffbt_pkg::S_RESP;
        end else begin
          blk_start_d = PW'(b_q);
          blk_size_d  = tag_size;
          blk_used_d  = 1'b0;
          split_d     = 1'b0;
          if (MW'(n_ptr) < MW'(HEAP_WORDS)) begin
            rd_en   = 1'b1;
            rd_addr = AW'(n_ptr);
            state_d = ffbt_pkg::S_F_NXT;
          end else begin
            state_d = ffbt_pkg::S_F_PRV;
          end
        end
      end

      ffbt_pkg::S_F_NXT: begin
        if (!tag_used) begin
          blk_size_d = PW'(blk_size_q + tag_size);
        end
        state_d = ffbt_pkg::S_F_PRV;
      end

      ffbt_pkg::S_F_PRV: begin
        if (b_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(b_q - ffbt_pkg::BIDX_W'(1));
          state_d = ffbt_pkg::S_F_PCHK;
        end else begin
          state_d = ffbt_pkg::S_W_HDR;
        end
      end

      ffbt_pkg::S_F_PCHK: begin
        if (!tag_used && tag_size != '0 && MW'(tag_size) <= MW'(b_q)) begin
          blk_start_d = PW'(blk_start_q - tag_size);
          blk_size_d  = PW'(blk_size_q + tag_size);
        end
        state_d = ffbt_pkg::S_W_HDR;
      end

      ffbt_pkg::S_W_HDR: begin
        wr_en   = 1'b1;
        state_d = ffbt_pkg::S_W_TRL;
      end

      ffbt_pkg::S_W_TRL: begin
        wr_en   = 1'b1;
        wr_addr = AW'(blk_start_q + blk_size_q - PW'(1));
        if (split_q) begin
          // Advance to the free remainder behind the granted block
          blk_start_d = PW'(blk_start_q + blk_size_q);
          blk_size_d  = rest_size_q;
          blk_used_d  = 1'b0;
          split_d     = 1'b0;
          state_d     = ffbt_pkg::S_W_HDR;
        end else begin
          state_d = ffbt_pkg::S_RESP;
        end
      end

      ffbt_pkg::S_RESP: begin
        // Hold until the output register is free
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_off_d    = res_off_q;
          state_d      = ffbt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ffbt_pkg::S_IDLE;
      end
    endcase
  end

  // A failed allocate never carries an offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ffbt_pkg::STATUS_NO_FIT |-> rsp_o.payload_offset == '0)
    else $error("failed allocate carries an offset");

  // Granted offsets are word aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.payload_offset[ffbt_pkg::WORD_SHIFT-1:0] == '0)
    else $error("unaligned payload offset");

  // An accepted beat keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while busy");

  // The tag memory is never written while the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ffbt_pkg::S_IDLE |-> !wr_en)
    else $error("tag write while idle");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the first-fit boundary-tag heap allocator.
`timescale 1ns / 100ps

module tb;

  localparam int HEAP_WORDS = ffbt_pkg::HEAP_WORDS_DEF;
  // Tag size field: holds 0 .. HEAP_WORDS
  localparam int SIZE_W = $clog2(HEAP_WORDS) + 1;

  localparam int RANDOM_ITEMS     = 1426;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int HOLD_AT_ITEM     = 150;
  localparam int DRAIN_AT_ITEM    = 700;
  localparam int FLUSH_EVERY      = 350;
  localparam int FLUSH_AT         = 300;
  localparam int SETTLE_CYCLES    = 50;
  // Worst walk covers up to 512 blocks, plus the longest gap on each side, per
  // item; this limit is several times that over the whole run.
  localparam int CYCLE_LIMIT      = 8_000_000;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic [SIZE_W-1:0] words;
    logic              used;
  } tag_t;

  typedef struct packed {
    logic                       status;
    logic [ffbt_pkg::OFF_W-1:0] offset;
  } grant_t;

  // One row of the directed script; the grant is used only when typed is set
  typedef struct packed {
    logic                       cmd;
    logic [ffbt_pkg::REQ_W-1:0] byte_count;
    logic [ffbt_pkg::OFF_W-1:0] release_at;
    logic                       typed;
    logic                       status;
    logic [ffbt_pkg::OFF_W-1:0] grant_offset;
  } script_row_t;

  localparam int SCRIPT_ROWS = 24;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // zero-byte request right after reset: tags only, at the heap start
    '{ffbt_pkg::CMD_ALLOC, 13'd0,    13'd8191, TYPED,     ffbt_pkg::STATUS_DONE,   13'd8},
    // request too large for the whole heap
    '{ffbt_pkg::CMD_ALLOC, 13'd8191, 13'd0,    TYPED,     ffbt_pkg::STATUS_NO_FIT, 13'd0},
    '{ffbt_pkg::CMD_ALLOC, 13'd1,    13'd8191, PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_ALLOC, 13'd8,    13'd0,    PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    // bad release offsets: below one word, misaligned, off a block start
    '{ffbt_pkg::CMD_FREE,  13'd8191, 13'd0,    TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd0,    13'd4,    TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd8191, 13'd8191, TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd0,    13'd8184, TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    // release, then release again (double free)
    '{ffbt_pkg::CMD_FREE,  13'd8191, 13'd24,   TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd0,    13'd24,   TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    // merge with free neighbours on both sides
    '{ffbt_pkg::CMD_FREE,  13'd8191, 13'd48,   TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_ALLOC, 13'd8168, 13'd0,    PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_ALLOC, 13'd8160, 13'd8191, PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd0,    13'd8,    TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_ALLOC, 13'd0,    13'd0,    PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd8191, 13'd24,   TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd0,    13'd8,    TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    // exactly the whole heap, then nothing left
    '{ffbt_pkg::CMD_ALLOC, 13'd8176, 13'd8191, PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_ALLOC, 13'd0,    13'd0,    PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd8191, 13'd8,    TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    // split, then a fit whose leftover is too small to split off
    '{ffbt_pkg::CMD_ALLOC, 13'd7,    13'd8191, PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_ALLOC, 13'd8144, 13'd0,    PREDICTED, ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd0,    13'd32,   TYPED,     ffbt_pkg::STATUS_DONE,   13'd0},
    '{ffbt_pkg::CMD_FREE,  13'd8191, 13'd8,    TYPED,     ffbt_pkg::STATUS_DONE,   13'd0}
  };

  logic clk_i;
  logic rst_ni;

  ffbt_req_if req_if ();
  ffbt_rsp_if rsp_if ();

  first_fit_boundary_tag_allocator_unit #(
    .HEAP_WORDS(HEAP_WORDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow heap: one tag per word, as the block keeps it
  tag_t                       heap_tags [HEAP_WORDS];
  grant_t                     grants_due [$];
  logic [ffbt_pkg::OFF_W-1:0] held_offsets [$];
  logic [ffbt_pkg::OFF_W-1:0] released_offsets [$];
  int                         mismatches;
  int unsigned                cycle_count;
  bit                         long_hold_req;
  bit                         long_hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Write a block's header and trailer; drop writes that would leave the heap
  function automatic void write_block(input int unsigned start, input int unsigned words,
                                      input logic used);
    tag_t t;
    if (words == 0 || start >= HEAP_WORDS || words > HEAP_WORDS - start) return;
    t.words = SIZE_W'(words);
    t.used  = used;
    heap_tags[start]             = t;
    heap_tags[start + words - 1] = t;
  endfunction

  function automatic void reset_heap();
    foreach (heap_tags[i]) heap_tags[i] = '0;
    write_block(0, HEAP_WORDS, 1'b0);
  endfunction

  // First fit from the heap start; split when three or more words are left
  function automatic grant_t predict_alloc(input logic [ffbt_pkg::REQ_W-1:0] byte_count);
    int unsigned need;
    int unsigned p;
    int unsigned sz;
    tag_t        t;
    grant_t      g;
    need     = (32'(byte_count) + 7) / 8 + ffbt_pkg::TAG_WORDS;
    g.status = ffbt_pkg::STATUS_NO_FIT;
    g.offset = '0;
    p        = 0;
    while (p < HEAP_WORDS) begin
      t  = heap_tags[p];
      sz = t.words;
      if (sz == 0) break;
      if (!t.used && sz >= need) begin
        if (sz - need >= ffbt_pkg::MIN_SPLIT_WORDS) begin
          write_block(p, need, 1'b1);
          write_block(p + need, sz - need, 1'b0);
        end else begin
          write_block(p, sz, 1'b1);
        end
        g.status = ffbt_pkg::STATUS_DONE;
        g.offset = ffbt_pkg::OFF_W'((p + 1) * 8);
        return g;
      end
      p += sz;
    end
    return g;
  endfunction

  // Release a used block named by its payload offset and merge free neighbours.
  // Return whether anything was released.
  function automatic bit predict_release(input logic [ffbt_pkg::OFF_W-1:0] release_at);
    int unsigned b;
    int unsigned p;
    int unsigned sz;
    int unsigned n;
    tag_t        pt;
    if (release_at < 8 || release_at[ffbt_pkg::WORD_SHIFT-1:0] != '0) return 1'b0;
    b = release_at[ffbt_pkg::OFF_W-1:ffbt_pkg::WORD_SHIFT] - 1;
    p = 0;
    while (p < HEAP_WORDS && p < b) begin
      sz = heap_tags[p].words;
      if (sz == 0) return 1'b0;
      p += sz;
    end
    if (p != b || b >= HEAP_WORDS || !heap_tags[b].used) return 1'b0;
    sz = heap_tags[b].words;
    write_block(b, sz, 1'b0);
    n = b + sz;
    if (n < HEAP_WORDS && !heap_tags[n].used) begin
      sz += heap_tags[n].words;
      write_block(b, sz, 1'b0);
    end
    if (b > 0) begin
      pt = heap_tags[b - 1];
      if (!pt.used && pt.words != 0 && pt.words <= b) write_block(b - pt.words, pt.words + sz, 1'b0);
    end
    return 1'b1;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int draw_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request beat, hold it until taken, then queue its expected grant.
  // Entered at a rising edge; returns at the edge where the beat was taken.
  task automatic put_request(input logic cmd, input logic [ffbt_pkg::REQ_W-1:0] byte_count,
                             input logic [ffbt_pkg::OFF_W-1:0] release_at, input int gap,
                             input bit drain, input bit typed, input grant_t typed_grant);
    grant_t due;
    int     hit[$];
    if (gap > 0 || drain) req_if.valid <= 1'b0;
    // wait for every outstanding grant before offering more
    if (drain) do @(posedge clk_i); while (grants_due.size() != 0);
    repeat (gap) @(posedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.cmd         <= cmd;
    req_if.req_bytes   <= byte_count;
    req_if.free_offset <= release_at;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    due = '{status: ffbt_pkg::STATUS_DONE, offset: '0};
    if (cmd == ffbt_pkg::CMD_ALLOC) begin
      due = predict_alloc(byte_count);
      if (due.status == ffbt_pkg::STATUS_DONE) held_offsets.push_back(due.offset);
    end else if (predict_release(release_at)) begin
      hit = held_offsets.find_first_index(x) with (x == release_at);
      if (hit.size() != 0) held_offsets.delete(hit[0]);
      released_offsets.push_back(release_at);
      if (released_offsets.size() > 16) void'(released_offsets.pop_front());
    end
    grants_due.push_back(typed ? typed_grant : due);
  endtask

  // Grant checker: compare each taken response beat with the oldest expectation
  always @(posedge clk_i) begin : check_grants
    grant_t due;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (grants_due.size() == 0) begin
        report_mismatch($sformatf("unexpected response status=%0d offset=%0d",
                                  rsp_if.status, rsp_if.payload_offset));
      end else begin
        due = grants_due.pop_front();
        if (rsp_if.status !== due.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, due.status));
        if (rsp_if.payload_offset !== due.offset)
          report_mismatch($sformatf("payload_offset %0d, expected %0d",
                                    rsp_if.payload_offset, due.offset));
      end
    end
  end

  // Response side: random back-pressure, calm stretches, and one long hold-off
  // while the sender keeps offering so that the block backs up into its input
  initial begin : grant_sink
    int  gap;
    bit  calm;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 200)) begin
        if (long_hold_req && !long_hold_done) begin
          rsp_if.ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
          long_hold_done = 1'b1;
        end
        gap = draw_gap(calm);
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run if it hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Request side: reset, directed script, then random traffic
  initial begin : request_source
    logic                       cmd;
    logic [ffbt_pkg::REQ_W-1:0] byte_count;
    logic [ffbt_pkg::OFF_W-1:0] release_at;
    int unsigned                pick;
    bit                         sender_calm;
    bit                         flushing;
    grant_t                     typed_grant;

    mismatches         = 0;
    long_hold_req      = 1'b0;
    long_hold_done     = 1'b0;
    sender_calm        = 1'b0;
    flushing           = 1'b0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.cmd         <= ffbt_pkg::CMD_ALLOC;
    req_if.req_bytes   <= '0;
    req_if.free_offset <= '0;
    reset_heap();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed script; frees and fresh-heap rows carry their grant
    foreach (SCRIPT[i]) begin
      typed_grant.status = SCRIPT[i].status;
      typed_grant.offset = SCRIPT[i].grant_offset;
      put_request(SCRIPT[i].cmd, SCRIPT[i].byte_count, SCRIPT[i].release_at,
                  draw_gap(1'b0), 1'b0, SCRIPT[i].typed, typed_grant);
    end

    // random traffic: mostly allocate/release of live blocks, some noise,
    // and a periodic flush that returns the heap to a single free block
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      if (n == HOLD_AT_ITEM) long_hold_req = 1'b1;
      if (n % FLUSH_EVERY == FLUSH_AT) flushing = 1'b1;
      if (held_offsets.size() == 0) flushing = 1'b0;

      cmd        = ffbt_pkg::CMD_ALLOC;
      byte_count = ffbt_pkg::REQ_W'($urandom);
      release_at = ffbt_pkg::OFF_W'($urandom);
      pick       = $urandom_range(0, 99);

      if (flushing) begin
        cmd        = ffbt_pkg::CMD_FREE;
        release_at = held_offsets[$urandom_range(0, held_offsets.size() - 1)];
      end else if (pick < 52 || held_offsets.size() == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 78)      byte_count = ffbt_pkg::REQ_W'($urandom_range(0, 120));
        else if (pick < 92) byte_count = ffbt_pkg::REQ_W'($urandom_range(121, 1000));
        else if (pick < 97) byte_count = ffbt_pkg::REQ_W'($urandom_range(1001, 8191));
        else if (pick < 98) byte_count = '0;
        else if (pick < 99) byte_count = '1;
        else                byte_count = ffbt_pkg::REQ_W'($urandom_range(1, 8));
      end else if (pick < 90) begin
        cmd        = ffbt_pkg::CMD_FREE;
        release_at = held_offsets[$urandom_range(0, held_offsets.size() - 1)];
      end else begin
        // noise: double free, misaligned or stray offset
        cmd = ffbt_pkg::CMD_FREE;
        case ($urandom_range(0, 2))
          0: if (released_offsets.size() != 0)
               release_at = released_offsets[$urandom_range(0, released_offsets.size() - 1)];
          1: if (held_offsets.size() != 0)
               release_at = held_offsets[$urandom_range(0, held_offsets.size() - 1)]
                            + ffbt_pkg::OFF_W'($urandom_range(1, 7));
          default: ;
        endcase
      end

      put_request(cmd, byte_count, release_at, draw_gap(sender_calm),
                  n == DRAIN_AT_ITEM, PREDICTED, '0);
    end

    req_if.valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
